// ===== rtl/rbb_pkg.sv =====
// shared types and constants of the rgb box blur
package rbb_pkg;

	localparam int MAX_RADIUS_DEF = 10;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int PIX_W     = 8;
	localparam int RADIUS_W  = 4;
	localparam int SIZE_W    = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_MUL,
		ST_CMP,
		ST_MOD,
		ST_SWEEP,
		ST_TAIL,
		ST_DSTART,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/rbb_div.sv =====
// restoring divider, one quotient bit per cycle
module rbb_div #(
	parameter int N = 18,
	parameter int D = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         busy,
	output logic [N-1:0] quo,
	output logic [D-1:0] rem
);

	localparam int CNT_W = $clog2(N + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [N-1:0]     quo_q;
	logic [D-1:0]     rem_q;
	logic [D:0]       trial;
	logic             ge;

	always_comb begin
		trial = {rem_q, quo_q[N-1]};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(N);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[N-2:0], ge};
			rem_q <= ge ? D'(trial - {1'b0, divisor}) : D'(trial);
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/rgb_box_blur_replicate_border.sv =====
// top level: streaming rgb box blur with replicated frame border
// Each accepted item (pixel or drain) is handled alone. An item that frees no output passes
// through the write, multiply and compare states back to idle; one that releases an output
// then sweeps its (2*radius+1)^2 window, limited by the single read port of the line store
// to one window pixel per cycle, and runs the bit-serial dividers for the three means.
// The store line of the window's top row comes from a reciprocal multiplication.
// The line store needs no clearing after reset. The finished pixel waits in an output
// register, so the next item may be taken while it is pending.
module rgb_box_blur_replicate_border #(
	parameter int MAX_RADIUS = rbb_pkg::MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [rbb_pkg::PIX_W-1:0]     in_red,
	input  logic [rbb_pkg::PIX_W-1:0]     in_green,
	input  logic [rbb_pkg::PIX_W-1:0]     in_blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rbb_pkg::PIX_W-1:0]     out_red,
	output logic [rbb_pkg::PIX_W-1:0]     out_green,
	output logic [rbb_pkg::PIX_W-1:0]     out_blue,
	output logic                          frame_last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbb_pkg::SIZE_W-1:0]    cfg_data
);

	import rbb_pkg::*;

	localparam int STORE_LINES = 2 * MAX_RADIUS + 2;
	localparam int LW          = $clog2(STORE_LINES);
	localparam int CW          = $clog2(MAX_WIDTH);
	localparam int WW          = $clog2(MAX_WIDTH + 1);
	localparam int RW          = $clog2(MAX_HEIGHT + 1);
	localparam int KW          = $clog2(2 * MAX_RADIUS + 1);
	localparam int SW          = (WW > RW ? WW : RW) + 2;
	localparam int AREA_MAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int AW          = $clog2(AREA_MAX + 1);
	localparam int SUMW        = $clog2(AREA_MAX * 255 + 1);
	localparam int PW          = RW + WW + 1;
	localparam int DEPTH       = STORE_LINES * (1 << CW);
	localparam int AD          = LW + CW;
	localparam int PXW         = 3 * PIX_W;
	localparam int MOD_SH      = RW + LW;
	localparam longint MOD_K   = ((longint'(1) << MOD_SH) + longint'(STORE_LINES) - 1)
		/ longint'(STORE_LINES);
	localparam int MPW         = RW + MOD_SH;

	function automatic logic [SW-1:0] clamp_pos(input logic signed [SW-1:0] v,
		input logic signed [SW-1:0] hi);
		logic [SW-1:0] res;
		if (v < 0) begin
			res = '0;
		end else if (v > hi) begin
			res = hi;
		end else begin
			res = v;
		end
		return res;
	endfunction

	state_t state_q, state_d;

	logic [RADIUS_W-1:0] radius_q;
	logic [SIZE_W-1:0]   fwidth_q;
	logic [SIZE_W-1:0]   fheight_q;

	logic [RADIUS_W-1:0] r_eff;
	logic [WW-1:0]       w_eff, w_m1;
	logic [RW-1:0]       h_eff, h_m1;
	logic [AW-1:0]       area;

	logic [CW-1:0] in_col_q, out_col_q, cx_q;
	logic [RW-1:0] in_row_q, out_row_q, cy_q, y_q;
	logic [LW-1:0] in_line_q, line_q;
	logic [KW-1:0] dx_q, dy_q;

	logic           req_q;
	logic [PXW-1:0] pix_q;
	logic [PW-1:0]  arr_q, need_q, arr_d, need_d;

	logic [PXW-1:0] mem [DEPTH];
	logic [PXW-1:0] rd_q;
	logic           rd_pend_q;
	logic           wr_en, rd_en;
	logic [AD-1:0]  wr_addr, rd_addr;
	logic [CW-1:0]  wr_col;
	logic           in_wrap;

	logic [RW-1:0] nr, cy, y0, y_next;
	logic [CW-1:0] nc, cx, x_pos;
	logic [RW:0]   nr_full;
	logic [WW:0]   nc_full;
	logic signed [SW-1:0] x_hi, y_hi;

	logic hit, mod_start, div_start, sweep_end, row_end, last;
	logic div_busy, div_busy_g, div_busy_b;
	logic [MPW-1:0] mod_prod;
	logic [RW-1:0]  mod_quo;
	logic [LW-1:0]  mod_rem;

	logic [SUMW-1:0] sum_r, sum_g, sum_b;
	logic [SUMW-1:0] quo_r, quo_g, quo_b;
	logic [AW-1:0]   rem_r, rem_g, rem_b;

	logic               out_valid_q, frame_last_q;
	logic [PIX_W-1:0]   out_red_q, out_green_q, out_blue_q;
	logic               load_out;

	// effective sizes
	always_comb begin
		r_eff = (int'(radius_q) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : radius_q;
		if (fwidth_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(fwidth_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fwidth_q);
		end
		if (fheight_q == '0) begin
			h_eff = RW'(1);
		end else if (int'(fheight_q) > MAX_HEIGHT) begin
			h_eff = RW'(MAX_HEIGHT);
		end else begin
			h_eff = RW'(fheight_q);
		end
		w_m1 = w_eff - 1'b1;
		h_m1 = h_eff - 1'b1;
		x_hi = SW'(w_m1);
		y_hi = SW'(h_m1);
		area = AW'((2 * int'(r_eff) + 1) * (2 * int'(r_eff) + 1));
	end

	// input side addressing
	always_comb begin
		wr_col  = (WW'(in_col_q) < w_eff) ? in_col_q : CW'(w_m1);
		in_wrap = ((WW + 1)'(in_col_q) + 1'b1) >= (WW + 1)'(w_eff);
		wr_en   = (state_q == ST_WRITE) && !req_q && (in_row_q < h_eff);
		wr_addr = {in_line_q, wr_col};
	end

	// window readiness
	always_comb begin
		nr_full = (RW + 1)'(out_row_q) + (RW + 1)'(r_eff);
		nr      = (nr_full > (RW + 1)'(h_m1)) ? h_m1 : RW'(nr_full);
		nc_full = (WW + 1)'(out_col_q) + (WW + 1)'(r_eff);
		nc      = (nc_full > (WW + 1)'(w_m1)) ? CW'(w_m1) : CW'(nc_full);
		arr_d   = PW'(in_row_q) * PW'(w_eff) + PW'(in_col_q);
		need_d  = PW'(nr) * PW'(w_eff) + PW'(nc);
		hit     = arr_q > need_q;
	end

	// store line of the top window row, by reciprocal multiplication
	always_comb begin
		mod_prod = MPW'(y_q) * MPW'(MOD_K);
		mod_quo  = RW'(mod_prod >> MOD_SH);
		mod_rem  = LW'(MPW'(y_q) - MPW'(mod_quo) * MPW'(STORE_LINES));
	end

	// window geometry
	always_comb begin
		cy     = (out_row_q < h_eff) ? out_row_q : h_m1;
		cx     = (WW'(out_col_q) < w_eff) ? out_col_q : CW'(w_m1);
		y0     = RW'(clamp_pos(SW'(cy) - SW'(r_eff), y_hi));
		y_next = RW'(clamp_pos(SW'(cy_q) - SW'(r_eff) + SW'(dy_q) + SW'(1), y_hi));
		x_pos  = CW'(clamp_pos(SW'(cx_q) - SW'(r_eff) + SW'(dx_q), x_hi));
		rd_en  = state_q == ST_SWEEP;
		rd_addr = {line_q, x_pos};
		row_end   = int'(dx_q) == 2 * int'(r_eff);
		sweep_end = row_end && (int'(dy_q) == 2 * int'(r_eff));
		last = (out_row_q >= h_m1) && (WW'(out_col_q) >= w_m1);
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		mod_start = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE:  state_d = ST_MUL;
			ST_MUL:    state_d = ST_CMP;
			ST_CMP: begin
				if (hit) begin
					mod_start = 1'b1;
					state_d   = ST_MOD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MOD:    state_d = ST_SWEEP;
			ST_SWEEP: begin
				if (sweep_end) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL:   state_d = ST_DSTART;
			ST_DSTART: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_W'(10);
			fwidth_q  <= SIZE_W'(1024);
			fheight_q <= SIZE_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS: radius_q  <= cfg_data[RADIUS_W-1:0];
				REG_WIDTH:  fwidth_q  <= cfg_data;
				REG_HEIGHT: fheight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position counters and window walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_line_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= rd_en;
			if (wr_en) begin
				if (in_wrap) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 1'b1;
					in_line_q <= (int'(in_line_q) == STORE_LINES - 1) ? '0 : in_line_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (mod_start) begin
				dx_q <= '0;
				dy_q <= '0;
			end else if (rd_en) begin
				if (row_end) begin
					dx_q <= '0;
					dy_q <= dy_q + 1'b1;
				end else begin
					dx_q <= dx_q + 1'b1;
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end else if (load_out) begin
				out_valid_q <= 1'b1;
			end
			if (load_out) begin
				if (last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					in_line_q <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (WW'(out_col_q) >= w_m1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_q <= req_type;
			pix_q <= {in_blue, in_green, in_red};
		end
		if (state_q == ST_MUL) begin
			arr_q  <= arr_d;
			need_q <= need_d;
		end
		if (mod_start) begin
			cy_q  <= cy;
			cx_q  <= cx;
			y_q   <= y0;
			sum_r <= '0;
			sum_g <= '0;
			sum_b <= '0;
		end
		if (state_q == ST_MOD) begin
			line_q <= mod_rem;
		end else if (rd_en && row_end && !sweep_end && (y_next != y_q)) begin
			line_q <= (int'(line_q) == STORE_LINES - 1) ? '0 : line_q + 1'b1;
		end
		if (rd_en && row_end) begin
			y_q <= y_next;
		end
		if (rd_pend_q) begin
			sum_r <= sum_r + SUMW'(rd_q[PIX_W-1:0]);
			sum_g <= sum_g + SUMW'(rd_q[2*PIX_W-1:PIX_W]);
			sum_b <= sum_b + SUMW'(rd_q[3*PIX_W-1:2*PIX_W]);
		end
		if (load_out) begin
			out_red_q    <= quo_r[PIX_W-1:0];
			out_green_q  <= quo_g[PIX_W-1:0];
			out_blue_q   <= quo_b[PIX_W-1:0];
			frame_last_q <= last;
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= pix_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	rbb_div #(.N(SUMW), .D(AW)) u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_r),
		.divisor  (area),
		.busy     (div_busy),
		.quo      (quo_r),
		.rem      (rem_r)
	);

	rbb_div #(.N(SUMW), .D(AW)) u_div_g (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_g),
		.divisor  (area),
		.busy     (div_busy_g),
		.quo      (quo_g),
		.rem      (rem_g)
	);

	rbb_div #(.N(SUMW), .D(AW)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_b),
		.divisor  (area),
		.busy     (div_busy_b),
		.quo      (quo_b),
		.rem      (rem_b)
	);

	assign in_stall   = state_q != ST_IDLE;
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign out_red    = out_red_q;
	assign out_green  = out_green_q;
	assign out_blue   = out_blue_q;
	assign frame_last = frame_last_q;

endmodule

// ===== rtl/rbb_checker.sv =====
// port level checks for the rgb box blur, bound to the top level
module rbb_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [rbb_pkg::PIX_W-1:0] out_red,
	input logic [rbb_pkg::PIX_W-1:0] out_green,
	input logic [rbb_pkg::PIX_W-1:0] out_blue,
	input logic                      frame_last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(frame_last))
		else $error("stalled result changed");

	// one transaction at a time on the input
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// a new result only comes out of a busy spell
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall) && $past(in_stall, 2))
		else $error("result without work");

endmodule

bind rgb_box_blur_replicate_border rbb_checker u_rbb_checker (.*);

// ===== bench/tb_rgb_box_blur_replicate_border.sv =====
// self-checking regression bench for the streaming rgb box blur
`timescale 1ns / 1ps

module tb_rgb_box_blur_replicate_border;
	import rbb_pkg::*;

	localparam int LINES = 2 * MAX_RADIUS_DEF + 2;
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} blur_pix_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 req_type;
	logic [PIX_W-1:0]     in_red, in_green, in_blue;
	logic                 out_valid;
	logic                 out_stall;
	logic [PIX_W-1:0]     out_red, out_green, out_blue;
	logic                 frame_last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;

	// model state
	logic [23:0] pix_store [0:LINES*MAX_WIDTH_DEF-1];
	int unsigned mdl_radius, mdl_width, mdl_height;
	int unsigned wr_col, wr_row, rd_col, rd_row;
	bit          frame_done;

	blur_pix_t   blur_queue[$];
	int          errors = 0;
	int          items_sent = 0;
	int          pixels_out = 0;
	int          frames_run = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;

	rgb_box_blur_replicate_border dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int unsigned eff_size(int unsigned v, int unsigned maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic int unsigned eff_radius();
		return (mdl_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : mdl_radius;
	endfunction

	task automatic predict_blur(input logic kind, input logic [7:0] r, g, b);
		int unsigned rad, w, h, nr, nc, col, area, sr, sg, sb;
		longint unsigned arrived, needed;
		int cy, cx, y, x;
		logic [23:0] p;
		blur_pix_t res;
		rad = eff_radius();
		w = eff_size(mdl_width, MAX_WIDTH_DEF);
		h = eff_size(mdl_height, MAX_HEIGHT_DEF);
		if (kind == REQ_PIXEL && wr_row < h) begin
			col = (wr_col < w) ? wr_col : w - 1;
			pix_store[(wr_row % LINES) * MAX_WIDTH_DEF + col] = {b, g, r};
			if (wr_col + 1 >= w) begin
				wr_col = 0;
				wr_row++;
			end else begin
				wr_col++;
			end
		end
		nr = rd_row + rad;
		if (nr > h - 1) nr = h - 1;
		nc = rd_col + rad;
		if (nc > w - 1) nc = w - 1;
		arrived = longint'(wr_row) * w + wr_col;
		needed = longint'(nr) * w + nc;
		if (arrived <= needed) return;
		cy = (rd_row < h) ? rd_row : h - 1;
		cx = (rd_col < w) ? rd_col : w - 1;
		sr = 0;
		sg = 0;
		sb = 0;
		for (int dy = -int'(rad); dy <= int'(rad); dy++) begin
			y = cy + dy;
			if (y < 0) y = 0;
			if (y > int'(h) - 1) y = h - 1;
			for (int dx = -int'(rad); dx <= int'(rad); dx++) begin
				x = cx + dx;
				if (x < 0) x = 0;
				if (x > int'(w) - 1) x = w - 1;
				p = pix_store[(y % LINES) * MAX_WIDTH_DEF + (x % MAX_WIDTH_DEF)];
				sr += 32'(p[7:0]);
				sg += 32'(p[15:8]);
				sb += 32'(p[23:16]);
			end
		end
		area = (2 * rad + 1) * (2 * rad + 1);
		res.red = 8'(sr / area);
		res.green = 8'(sg / area);
		res.blue = 8'(sb / area);
		res.last = (rd_row >= h - 1) && (rd_col >= w - 1);
		blur_queue.push_back(res);
		if (res.last) begin
			wr_col = 0;
			wr_row = 0;
			rd_col = 0;
			rd_row = 0;
			frame_done = 1'b1;
		end else if (rd_col >= w - 1) begin
			rd_col = 0;
			rd_row++;
		end else begin
			rd_col++;
		end
	endtask

	task automatic send_item(input logic kind, input logic [7:0] r, g, b);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		in_red <= r;
		in_green <= g;
		in_blue <= b;
		do @(posedge clk); while (in_stall);
		predict_blur(kind, r, g, b);
		items_sent++;
	endtask

	task automatic send_random(input logic kind);
		send_item(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// waits for the block to settle, then writes one register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
		in_valid <= 1'b0;
		wait (blur_queue.size() == 0);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RADIUS: mdl_radius = 32'(val & 11'hF);
			REG_WIDTH:  mdl_width = 32'(val);
			REG_HEIGHT: mdl_height = 32'(val);
			default: ;
		endcase
	endtask

	task automatic set_shape(input logic [SIZE_W-1:0] rad, w, h);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	// one whole frame: random pixels, optional drains mid frame, then flushing items
	task automatic run_frame(input int drain_pct);
		int unsigned npix;
		npix = eff_size(mdl_width, MAX_WIDTH_DEF) * eff_size(mdl_height, MAX_HEIGHT_DEF);
		frame_done = 1'b0;
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(0, 99) < drain_pct) send_random(REQ_DRAIN);
			send_random(REQ_PIXEL);
		end
		while (!frame_done) send_random(1'($urandom_range(0, 1)));
		frames_run++;
	endtask

	task automatic test_directed_extremes();
		set_shape(11'd0, 11'd2, 11'd2);
		frame_done = 1'b0;
		send_item(REQ_PIXEL, 8'd0, 8'd0, 8'd0);
		send_item(REQ_PIXEL, 8'd255, 8'd255, 8'd255);
		send_item(REQ_DRAIN, 8'd255, 8'd0, 8'd255);
		send_item(REQ_PIXEL, 8'd255, 8'd0, 8'd170);
		send_item(REQ_PIXEL, 8'd0, 8'd255, 8'd85);
		while (!frame_done) send_item(REQ_DRAIN, 8'd0, 8'd0, 8'd0);
		set_shape(11'h7F1, 11'd3, 11'd3);
		frame_done = 1'b0;
		for (int i = 0; i < 9; i++)
			send_item(REQ_PIXEL, (i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd0 : 8'd255, 8'(i * 31));
		send_item(REQ_PIXEL, 8'd1, 8'd2, 8'd3);
		send_item(REQ_PIXEL, 8'd4, 8'd5, 8'd6);
		while (!frame_done) send_item(REQ_DRAIN, 8'd9, 8'd9, 8'd9);
	endtask

	task automatic test_size_limits();
		set_shape(11'd15, 11'd0, 11'd0);
		run_frame(20);
		set_shape(11'd15, 11'd4, 11'd3);
		run_frame(10);
		set_shape(11'd10, 11'd5, 11'd5);
		run_frame(0);
		set_shape(11'd1, 11'd2047, 11'd1);
		run_frame(0);
		set_shape(11'd2, 11'd1, 11'd40);
		run_frame(0);
	endtask

	task automatic test_backpressure();
		set_shape(11'd1, 11'd6, 11'd6);
		hold_req = 1'b1;
		run_frame(5);
		in_valid <= 1'b0;
		wait (blur_queue.size() == 0);
		repeat ($urandom_range(1, 19)) @(posedge clk);
		run_frame(5);
	endtask

	task automatic test_random_frames();
		int stop_at;
		stop_at = items_sent + 300;
		while (items_sent < stop_at) begin
			set_shape(SIZE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
				: $urandom_range(0, 3)),
				SIZE_W'($urandom_range(1, 12)), SIZE_W'($urandom_range(1, 8)));
			run_frame($urandom_range(0, 30));
		end
	endtask

	task automatic test_no_idling();
		quiet = 1'b1;
		for (int i = 0; i < 4; i++) begin
			set_shape(SIZE_W'($urandom_range(0, 2)), SIZE_W'($urandom_range(1, 10)),
				SIZE_W'($urandom_range(1, 6)));
			run_frame(10);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PIXEL;
		in_red = '0;
		in_green = '0;
		in_blue = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RADIUS;
		cfg_data = '0;
		for (int i = 0; i < LINES * MAX_WIDTH_DEF; i++) pix_store[i] = '0;
		mdl_radius = 10;
		mdl_width = 1024;
		mdl_height = 1024;
		wr_col = 0;
		wr_row = 0;
		rd_col = 0;
		rd_row = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_size_limits();
		test_backpressure();
		test_random_frames();
		test_no_idling();
		in_valid <= 1'b0;
		wait (blur_queue.size() == 0);
		repeat (600) @(posedge clk);
		$display("covered %0d items over %0d frames, %0d blurred pixels checked",
			items_sent, frames_run, pixels_out);
		$display("radius 0 to 15, sizes 0 to 2047, drains, surplus pixels and long stalls");
		if (errors == 0)
			$display("rgb_box_blur_replicate_border regression: pass");
		else
			$display("rgb_box_blur_replicate_border regression: fail");
		$finish;
	end

	// result side: checks each transaction, drives random stalls and a long stall when asked
	initial begin
		int stall_left;
		blur_pix_t exp_pix;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				pixels_out++;
				if (blur_queue.size() == 0) begin
					$error("unexpected output transaction");
					errors++;
				end else begin
					exp_pix = blur_queue.pop_front();
					if (out_red !== exp_pix.red) begin
						$error("out_red expected %0d actual %0d", exp_pix.red, out_red);
						errors++;
					end
					if (out_green !== exp_pix.green) begin
						$error("out_green expected %0d actual %0d", exp_pix.green, out_green);
						errors++;
					end
					if (out_blue !== exp_pix.blue) begin
						$error("out_blue expected %0d actual %0d", exp_pix.blue, out_blue);
						errors++;
					end
					if (frame_last !== exp_pix.last) begin
						$error("frame_last expected %0d actual %0d", exp_pix.last, frame_last);
						errors++;
					end
				end
			end
			if (hold_req && stall_left == 0) begin
				stall_left = 300;
				hold_req = 1'b0;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#40_000_000;
		$display("rgb_box_blur_replicate_border regression: fail");
		$finish;
	end

endmodule
